FILE: design/btc_pkg.sv
// Shared types and constants for the barometer temperature compensation block.
// No dependencies.
`timescale 1ns / 1ps

package btc_pkg;

  localparam int CoeffW   = 16;
  localparam int RawW     = 24;
  localparam int CfgIdxW  = 3;
  localparam int TempOutW = 19;
  localparam int PresOutW = 32;

  // TEMP = 2000 + tq; the -1500 test becomes tq + 3500 < 0
  localparam int TempBase   = 2000;
  localparam int TempVlowOf = 3500;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SENS     = 3'd0,
    REG_OFF      = 3'd1,
    REG_TCS      = 3'd2,
    REG_TCO      = 3'd3,
    REG_TREF     = 3'd4,
    REG_TEMPSENS = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [CoeffW-1:0] sens;
    logic [CoeffW-1:0] off;
    logic [CoeffW-1:0] tcs;
    logic [CoeffW-1:0] tco;
    logic [CoeffW-1:0] tref;
    logic [CoeffW-1:0] tempsens;
  } cfg_t;

  // First-order results plus second-order operands
  typedef struct packed {
    logic [RawW-1:0]     d1;
    logic signed [19:0]  temp;
    logic signed [18:0]  a;     // TEMP - 2000
    logic signed [19:0]  b;     // TEMP + 1500
    logic                lo;    // TEMP < 2000
    logic                vlo;   // TEMP < -1500
    logic [18:0]         t2;
    logic signed [35:0]  off;
    logic signed [35:0]  sens;
  } fo_t;

  // Compensated terms ready for the pressure product
  typedef struct packed {
    logic [RawW-1:0]     d1;
    logic signed [20:0]  temp;
    logic signed [41:0]  off;
    logic signed [41:0]  sens;
  } so_t;

endpackage

FILE: design/btc_cfg_regs.sv
// Calibration register file, six 16-bit words.
// Depends on btc_pkg.
`timescale 1ns / 1ps

module btc_cfg_regs import btc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               we_i,
  input  logic [CfgIdxW-1:0] idx_i,
  input  logic [CoeffW-1:0]  wdata_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (cfg_idx_e'(idx_i))
        REG_SENS:     cfg_d.sens     = wdata_i;
        REG_OFF:      cfg_d.off      = wdata_i;
        REG_TCS:      cfg_d.tcs      = wdata_i;
        REG_TCO:      cfg_d.tco      = wdata_i;
        REG_TREF:     cfg_d.tref     = wdata_i;
        REG_TEMPSENS: cfg_d.tempsens = wdata_i;
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/btc_first_order.sv
// First-order compensation: dT, coefficient products, TEMP, OFF, SENS, T2.
// Three register stages. Depends on btc_pkg.
`timescale 1ns / 1ps

module btc_first_order import btc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfg_t            cfg_i,
  input  logic            valid_i,
  input  logic [RawW-1:0] pressure_raw_i,
  input  logic [RawW-1:0] temperature_raw_i,
  output logic            valid_o,
  output fo_t             fo_o
);

  logic [2:0] vld_q;

  // stage 1: dT
  logic signed [24:0] dt_d, dt_q;
  logic [RawW-1:0]    d1_s1_q;

  // stage 2: products
  logic signed [41:0] pt_d, pt_q, po_d, po_q, ps_d, ps_q;
  logic signed [49:0] pdd_d, pdd_q;
  logic [RawW-1:0]    d1_s2_q;

  // stage 3: first-order values
  logic signed [18:0] tq;
  fo_t                fo_d, fo_q;

  assign dt_d = $signed({1'b0, temperature_raw_i}) - $signed({1'b0, cfg_i.tref, 8'b0});

  assign pt_d  = dt_q * $signed({1'b0, cfg_i.tempsens});
  assign po_d  = dt_q * $signed({1'b0, cfg_i.tco});
  assign ps_d  = dt_q * $signed({1'b0, cfg_i.tcs});
  assign pdd_d = dt_q * dt_q;

  assign tq = $signed(pt_q[41:23]);

  always_comb begin
    fo_d.d1   = d1_s2_q;
    fo_d.a    = tq;
    fo_d.temp = $signed({tq[18], tq}) + 20'(TempBase);
    fo_d.b    = $signed({tq[18], tq}) + 20'(TempVlowOf);
    fo_d.lo   = tq[18];
    fo_d.vlo  = fo_d.b[19];
    fo_d.t2   = pdd_q[49:31];
    fo_d.off  = $signed({4'b0, cfg_i.off, 16'b0}) + $signed({po_q[41], po_q[41:7]});
    fo_d.sens = $signed({5'b0, cfg_i.sens, 15'b0}) + $signed({{2{ps_q[41]}}, ps_q[41:8]});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    dt_q    <= dt_d;
    d1_s1_q <= pressure_raw_i;
    pt_q    <= pt_d;
    po_q    <= po_d;
    ps_q    <= ps_d;
    pdd_q   <= pdd_d;
    d1_s2_q <= d1_s1_q;
    fo_q    <= fo_d;
  end

  assign valid_o = vld_q[2];
  assign fo_o    = fo_q;

endmodule

FILE: design/btc_second_order.sv
// Second-order correction below 20 degrees: squares, OFF2/SENS2/T2 terms,
// then the corrected TEMP, OFF and SENS. Three register stages. Depends on btc_pkg.
`timescale 1ns / 1ps

module btc_second_order import btc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  fo_t  fo_i,
  output logic valid_o,
  output so_t  so_o
);

  logic [2:0] vld_q;

  // stage 1: squares
  logic signed [37:0] a2_full;
  logic signed [39:0] b2_full;
  logic [36:0]        a2_q, b2_q;
  fo_t                fo_s1_q;

  // stage 2: correction terms
  logic [39:0] five_a2, seven_b2;
  logic [40:0] eleven_b2;
  logic [40:0] off2_d, off2_q, sens2_d, sens2_q;
  logic [18:0] t2_d, t2_q;
  fo_t         fo_s2_q;

  // stage 3: corrected values
  so_t so_d, so_q;

  assign a2_full = fo_i.a * fo_i.a;
  assign b2_full = fo_i.b * fo_i.b;

  assign five_a2   = {3'b0, a2_q} + {1'b0, a2_q, 2'b0};
  assign seven_b2  = {b2_q, 3'b0} - {3'b0, b2_q};
  assign eleven_b2 = {1'b0, b2_q, 3'b0} + {3'b0, b2_q, 1'b0} + {4'b0, b2_q};

  always_comb begin
    off2_d  = '0;
    sens2_d = '0;
    t2_d    = '0;
    if (fo_s1_q.lo) begin
      off2_d  = {2'b0, five_a2[39:1]};
      sens2_d = {3'b0, five_a2[39:2]};
      t2_d    = fo_s1_q.t2;
      if (fo_s1_q.vlo) begin
        off2_d  = off2_d + {1'b0, seven_b2};
        sens2_d = sens2_d + {1'b0, eleven_b2[40:1]};
      end
    end
  end

  always_comb begin
    so_d.d1   = fo_s2_q.d1;
    so_d.temp = $signed({fo_s2_q.temp[19], fo_s2_q.temp}) - $signed({2'b0, t2_q});
    so_d.off  = $signed({{6{fo_s2_q.off[35]}}, fo_s2_q.off}) - $signed({1'b0, off2_q});
    so_d.sens = $signed({{6{fo_s2_q.sens[35]}}, fo_s2_q.sens}) - $signed({1'b0, sens2_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    a2_q    <= a2_full[36:0];
    b2_q    <= b2_full[36:0];
    fo_s1_q <= fo_i;
    off2_q  <= off2_d;
    sens2_q <= sens2_d;
    t2_q    <= t2_d;
    fo_s2_q <= fo_s1_q;
    so_q    <= so_d;
  end

  assign valid_o = vld_q[2];
  assign so_o    = so_q;

endmodule

FILE: design/btc_pressure.sv
// Pressure product d1*SENS as two partial products, then the scaled offset
// subtract and final shift. Two register stages. Depends on btc_pkg.
`timescale 1ns / 1ps

module btc_pressure import btc_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  so_t                        so_i,
  output logic                       valid_o,
  output logic signed [TempOutW-1:0] temperature_centideg_o,
  output logic signed [PresOutW-1:0] pressure_pa_o
);

  logic [1:0] vld_q;

  // stage 1: partial products, SENS = hi*2^21 + lo
  logic [44:0]        pp_lo_d, pp_lo_q;
  logic signed [45:0] pp_hi_d, pp_hi_q;
  logic signed [41:0] off_q;
  logic signed [20:0] temp_q;

  // stage 2: floor(d1*SENS / 2^21) = hi + floor(lo / 2^21)
  logic signed [47:0] acc;
  logic signed [TempOutW-1:0] temp_out_q;
  logic signed [PresOutW-1:0] pres_out_q;

  assign pp_lo_d = so_i.d1 * so_i.sens[20:0];
  assign pp_hi_d = $signed({1'b0, so_i.d1}) * $signed(so_i.sens[41:21]);

  assign acc = $signed({{2{pp_hi_q[45]}}, pp_hi_q})
             + $signed({24'b0, pp_lo_q[44:21]})
             - $signed({{6{off_q[41]}}, off_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    pp_lo_q    <= pp_lo_d;
    pp_hi_q    <= pp_hi_d;
    off_q      <= so_i.off;
    temp_q     <= so_i.temp;
    temp_out_q <= temp_q[TempOutW-1:0];
    pres_out_q <= acc[46:15];
  end

  assign valid_o                = vld_q[1];
  assign temperature_centideg_o = temp_out_q;
  assign pressure_pa_o          = pres_out_q;

endmodule

FILE: design/barometer_temperature_compensation_top.sv
// Barometer second-order temperature compensation, top level.
// Depends on btc_pkg, btc_cfg_regs, btc_first_order, btc_second_order, btc_pressure.
`timescale 1ns / 1ps

// Fully pipelined: one item is taken every cycle, busy is always low, and the
// results appear on valid_o one per item, in item order. The pipeline stages
// are dT, the coefficient products, first-order values, squares, correction
// terms, corrected values, the split d1*SENS product and the final
// subtract/shift. Results are shown for one cycle only and cannot be held off
// by the receiver. The user must write calibration words through
// cfg_we_i/cfg_idx_i/cfg_wdata_i only while no item is in flight; the block
// does not enforce this. Indexes six and seven are ignored.

module barometer_temperature_compensation_top import btc_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CfgIdxW-1:0]         cfg_idx_i,
  input  logic [CoeffW-1:0]          cfg_wdata_i,
  input  logic                       start,
  output logic                       busy,
  input  logic [RawW-1:0]            pressure_raw_i,
  input  logic [RawW-1:0]            temperature_raw_i,
  output logic                       valid_o,
  output logic signed [TempOutW-1:0] temperature_centideg_o,
  output logic signed [PresOutW-1:0] pressure_pa_o
);

  cfg_t cfg;
  logic fo_valid, so_valid;
  fo_t  fo;
  so_t  so;

  assign busy = 1'b0;

  btc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  btc_first_order u_first (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .valid_i           (start),
    .pressure_raw_i    (pressure_raw_i),
    .temperature_raw_i (temperature_raw_i),
    .valid_o           (fo_valid),
    .fo_o              (fo)
  );

  btc_second_order u_second (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fo_valid),
    .fo_i    (fo),
    .valid_o (so_valid),
    .so_o    (so)
  );

  btc_pressure u_pres (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .valid_i                (so_valid),
    .so_i                   (so),
    .valid_o                (valid_o),
    .temperature_centideg_o (temperature_centideg_o),
    .pressure_pa_o          (pressure_pa_o)
  );

endmodule
